/* sv/mftp_pkg.sv */
// Package: shared types, constants and helper functions of the MIDI track parser.
`timescale 1ns / 1ps
package mftp_pkg;

    localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
    localparam logic [14:0] TPQ_DEFAULT   = 15'd480;
    localparam int          PADDR_W       = 3;
    localparam logic [PADDR_W-1:0] ADDR_TPQ = '0;

    localparam logic [3:0] KIND_SYSEX = 4'd7;
    localparam logic [3:0] KIND_META  = 4'd8;
    localparam logic [3:0] KIND_BEND  = 4'd6;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_TAG      = 3'd1;
    localparam logic [2:0] ERR_STATUS   = 3'd2;
    localparam logic [2:0] ERR_NO_RS    = 3'd3;
    localparam logic [2:0] ERR_META_LEN = 3'd4;
    localparam logic [2:0] ERR_KEY_SMPTE = 3'd5;

    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] META_SMPTE = 8'h54;
    localparam logic [7:0] META_KEY   = 8'h59;

    typedef enum logic [4:0] {
        PH_TAG0, PH_TAG1, PH_TAG2, PH_TAG3,
        PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3,
        PH_DELTA, PH_STATUS, PH_DATA2, PH_SYSLEN, PH_SYSPAY,
        PH_METATYPE, PH_METALEN, PH_METAPAY, PH_DATA1
    } phase_t;

    typedef enum logic [0:0] {
        ST_IDLE, ST_TIME
    } top_state_t;

    typedef enum logic [1:0] {
        TU_IDLE, TU_MUL, TU_DIV
    } tu_state_t;

    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0: r = 8'h4D;
            2'd1: r = 8'h54;
            2'd2: r = 8'h72;
            default: r = 8'h6B;
        endcase
        return r;
    endfunction

    // {fixed, length}
    function automatic logic [3:0] fixed_meta_len(input logic [7:0] mtype);
        logic [3:0] r;
        unique case (mtype)
            8'h00: r = {1'b1, 3'd2};
            8'h20: r = {1'b1, 3'd1};
            8'h21: r = {1'b1, 3'd1};
            8'h2F: r = {1'b1, 3'd0};
            8'h51: r = {1'b1, 3'd3};
            8'h54: r = {1'b1, 3'd5};
            8'h58: r = {1'b1, 3'd4};
            8'h59: r = {1'b1, 3'd2};
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

/* sv/midi_file_track_parser_top.sv */
// Top level: byte-serial MIDI track chunk parser with APB time base register.
//
// Input channel s_*: one track byte per item, s_tuser marks the first byte of a new
// file (clears total time, tempo and running status before the byte).
// Output channel m_*: one event record per completed channel, sysex or meta event,
// or one error record; m_tuser carries the event kind, m_tlast marks track end.
// Timing: the record of a byte is registered and shows the next cycle after the byte is taken.
// A byte that ends a delta time starts a 28-step shift-add multiply
// of tempo by delta and a 52-step restoring divide by ticks_per_quarter*1000, both on
// one shared adder in mftp_time_unit; the next byte waits until both are done.
// s_tready is low while the time unit runs and while a record waits in the output
// register; a stalled receiver therefore holds the input side.
// Reset (aresetn low, synchronous) returns to tag search with tempo 500000, time
// base 480, zero times and no error. An error is sticky until reset.
// Register ticks_per_quarter lies at APB address 0.
`timescale 1ns / 1ps
module midi_file_track_parser_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // in_byte
    input  logic                          s_tuser,   // new_file
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // channel[3:0], first_data[11:4], event_value[51:12], delta_ticks[79:52],
    // track_time_ms[111:80], total_time_ms[143:112], error_code[146:144], zero pad
    output logic [151:0]                  m_tdata,
    output logic [3:0]                    m_tuser,   // event_kind
    output logic                          m_tlast,   // track_done
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mftp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mftp_pkg::*;

    top_state_t  state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] bcnt_reg, bcnt_next;
    logic [31:0] clen_reg, clen_next;
    logic [7:0]  rs_reg, rs_next;
    logic [27:0] vlq_reg, vlq_next;
    logic [27:0] hdelta_reg, hdelta_next;
    logic [27:0] pcnt_reg, pcnt_next;
    logic [39:0] pacc_reg, pacc_next;
    logic [7:0]  hfb_reg, hfb_next;
    logic [23:0] tempo_reg, tempo_next;
    logic [31:0] track_reg, track_next;
    logic [31:0] total_reg, total_next;
    logic [2:0]  err_reg, err_next;
    logic [14:0] tpq_reg;
    logic        mvalid_reg, mvalid_next;
    logic [151:0] mdata_reg, mdata_next;
    logic [3:0]  mkind_reg, mkind_next;
    logic        mlast_reg, mlast_next;

    logic        accept;
    logic [7:0]  b;
    logic [27:0] vlq_new;
    logic        vlq_end;
    logic [3:0]  flen;
    logic        fin, fail, meta_fin, tu_start;
    logic [3:0]  f_kind, f_ch;
    logic [7:0]  f_fd;
    logic [39:0] f_val, m_val;
    logic [2:0]  f_err;
    logic        done_flag;
    logic [3:0]  rs_hi;
    logic [39:0] pacc_shift;
    logic [14:0] tb;
    logic [24:0] divisor;
    logic        tu_done;
    logic [51:0] tu_quot;
    logic [32:0] track_sum;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign b        = s_tdata;
    assign vlq_new  = {vlq_reg[20:0], b[6:0]};
    assign vlq_end  = !b[7];
    assign rs_hi    = rs_next[7:4];
    assign pacc_shift = {pacc_reg[31:0], b};
    assign tb       = (tpq_reg == 15'd0) ? 15'd1 : tpq_reg;
    assign divisor  = ({10'd0, tb} << 10) - ({10'd0, tb} << 4) - ({10'd0, tb} << 3);
    assign track_sum = {1'b0, track_reg} + {1'b0, tu_quot[31:0]};

    mftp_time_unit u_time (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (tu_start),
        .tempo    (tempo_next),
        .delta    (vlq_new),
        .divisor  (divisor),
        .done     (tu_done),
        .quotient (tu_quot)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TPQ) ? {17'd0, tpq_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpq_reg <= TPQ_DEFAULT;
        end else if (psel && penable && pwrite && paddr == ADDR_TPQ) begin
            tpq_reg <= pwdata[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_TAG0;
            bcnt_reg   <= '0;
            clen_reg   <= '0;
            rs_reg     <= '0;
            vlq_reg    <= '0;
            hdelta_reg <= '0;
            pcnt_reg   <= '0;
            pacc_reg   <= '0;
            hfb_reg    <= '0;
            tempo_reg  <= TEMPO_DEFAULT;
            track_reg  <= '0;
            total_reg  <= '0;
            err_reg    <= ERR_NONE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            bcnt_reg   <= bcnt_next;
            clen_reg   <= clen_next;
            rs_reg     <= rs_next;
            vlq_reg    <= vlq_next;
            hdelta_reg <= hdelta_next;
            pcnt_reg   <= pcnt_next;
            pacc_reg   <= pacc_next;
            hfb_reg    <= hfb_next;
            tempo_reg  <= tempo_next;
            track_reg  <= track_next;
            total_reg  <= total_next;
            err_reg    <= err_next;
            mvalid_reg <= mvalid_next;
        end
        mdata_reg <= mdata_next;
        mkind_reg <= mkind_next;
        mlast_reg <= mlast_next;
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        bcnt_next   = bcnt_reg;
        clen_next   = clen_reg;
        rs_next     = rs_reg;
        vlq_next    = vlq_reg;
        hdelta_next = hdelta_reg;
        pcnt_next   = pcnt_reg;
        pacc_next   = pacc_reg;
        hfb_next    = hfb_reg;
        tempo_next  = tempo_reg;
        track_next  = track_reg;
        total_next  = total_reg;
        err_next    = err_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        mkind_next  = mkind_reg;
        mlast_next  = mlast_reg;
        fin = 1'b0;
        fail = 1'b0;
        meta_fin = 1'b0;
        tu_start = 1'b0;
        f_kind = '0;
        f_ch = '0;
        f_fd = '0;
        f_val = '0;
        f_err = ERR_NONE;
        m_val = '0;
        done_flag = 1'b0;
        flen = fixed_meta_len(hfb_reg);

        if (state_reg == ST_TIME && tu_done) begin
            track_next = (|tu_quot[51:32] || track_sum[32]) ? 32'hFFFF_FFFF
                                                             : track_sum[31:0];
            state_next = ST_IDLE;
        end

        if (accept) begin
            if (s_tuser) begin
                total_next = '0;
                tempo_next = TEMPO_DEFAULT;
                rs_next    = '0;
            end
            if (err_reg == ERR_NONE) begin
                if (phase_reg == PH_TAG0 || phase_reg == PH_TAG1 ||
                    phase_reg == PH_TAG2 || phase_reg == PH_TAG3) begin
                    if (b != tag_byte(phase_reg[1:0])) begin
                        fail  = 1'b1;
                        f_err = ERR_TAG;
                    end else begin
                        if (phase_reg == PH_TAG3) clen_next = '0;
                        phase_next = phase_t'(phase_reg + 5'd1);
                    end
                end else if (phase_reg == PH_LEN0 || phase_reg == PH_LEN1 ||
                             phase_reg == PH_LEN2 || phase_reg == PH_LEN3) begin
                    clen_next = {clen_reg[23:0], b};
                    if (phase_reg == PH_LEN3) begin
                        bcnt_next  = '0;
                        track_next = '0;
                        vlq_next   = '0;
                        phase_next = (clen_next != 32'd0) ? PH_DELTA : PH_TAG0;
                    end else begin
                        phase_next = phase_t'(phase_reg + 5'd1);
                    end
                end else begin
                    if (bcnt_reg != 32'hFFFF_FFFF) bcnt_next = bcnt_reg + 32'd1;
                    unique case (phase_reg)
                        PH_DELTA: begin
                            vlq_next = vlq_new;
                            if (vlq_end) begin
                                hdelta_next = vlq_new;
                                vlq_next    = '0;
                                tu_start    = 1'b1;
                                state_next  = ST_TIME;
                                phase_next  = PH_STATUS;
                            end
                        end
                        PH_STATUS: begin
                            if (b[7]) begin
                                if (b < 8'hF0) begin
                                    rs_next    = b;
                                    hfb_next   = '0;
                                    phase_next = PH_DATA1;
                                end else if (b == 8'hF0 || b == 8'hF7) begin
                                    rs_next    = '0;
                                    hfb_next   = b;
                                    vlq_next   = '0;
                                    phase_next = PH_SYSLEN;
                                end else if (b == 8'hFF) begin
                                    rs_next    = '0;
                                    phase_next = PH_METATYPE;
                                end else begin
                                    fail  = 1'b1;
                                    f_err = ERR_STATUS;
                                end
                            end else if (rs_next == 8'd0) begin
                                fail  = 1'b1;
                                f_err = ERR_NO_RS;
                            end else begin
                                hfb_next = b;
                                if (rs_hi == 4'hC || rs_hi == 4'hD) begin
                                    fin    = 1'b1;
                                    f_kind = rs_hi - 4'd8;
                                    f_ch   = rs_next[3:0];
                                    f_fd   = b;
                                end else begin
                                    phase_next = PH_DATA2;
                                end
                            end
                        end
                        PH_DATA1: begin
                            hfb_next = b;
                            if (rs_hi == 4'hC || rs_hi == 4'hD) begin
                                fin    = 1'b1;
                                f_kind = rs_hi - 4'd8;
                                f_ch   = rs_next[3:0];
                                f_fd   = b;
                            end else begin
                                phase_next = PH_DATA2;
                            end
                        end
                        PH_DATA2: begin
                            fin    = 1'b1;
                            f_kind = rs_hi - 4'd8;
                            f_ch   = rs_next[3:0];
                            f_fd   = hfb_reg;
                            f_val  = (f_kind == KIND_BEND)
                                   ? {26'd0, b[6:0], hfb_reg[6:0]} : {32'd0, b};
                        end
                        PH_SYSLEN: begin
                            vlq_next = vlq_new;
                            if (vlq_end) begin
                                pcnt_next = vlq_new;
                                pacc_next = {12'd0, vlq_new};
                                vlq_next  = '0;
                                if (vlq_new == 28'd0) begin
                                    fin    = 1'b1;
                                    f_kind = KIND_SYSEX;
                                    f_ch   = hfb_reg[3:0];
                                end else begin
                                    phase_next = PH_SYSPAY;
                                end
                            end
                        end
                        PH_SYSPAY: begin
                            pcnt_next = pcnt_reg - 28'd1;
                            if (pcnt_next == 28'd0) begin
                                fin    = 1'b1;
                                f_kind = KIND_SYSEX;
                                f_ch   = hfb_reg[3:0];
                                f_val  = pacc_reg;
                            end
                        end
                        PH_METATYPE: begin
                            hfb_next   = b;
                            vlq_next   = '0;
                            phase_next = PH_METALEN;
                        end
                        PH_METALEN: begin
                            vlq_next = vlq_new;
                            if (vlq_end) begin
                                pcnt_next = vlq_new;
                                vlq_next  = '0;
                                if (flen[3] && vlq_new != {25'd0, flen[2:0]}) begin
                                    fail  = 1'b1;
                                    f_err = ERR_META_LEN;
                                end else begin
                                    pacc_next = flen[3] ? 40'd0 : {12'd0, vlq_new};
                                    if (vlq_new == 28'd0) begin
                                        meta_fin = 1'b1;
                                        m_val    = pacc_next;
                                    end else begin
                                        phase_next = PH_METAPAY;
                                    end
                                end
                            end
                        end
                        PH_METAPAY: begin
                            if (flen[3]) pacc_next = pacc_shift;
                            pcnt_next = pcnt_reg - 28'd1;
                            if (pcnt_next == 28'd0) begin
                                meta_fin = 1'b1;
                                m_val    = pacc_next;
                            end
                        end
                        default: phase_next = PH_TAG0;
                    endcase
                end

                if (meta_fin) begin
                    if (hfb_reg == META_TEMPO) tempo_next = m_val[23:0];
                    if ((hfb_reg == META_KEY && m_val[7:0] > 8'd1) ||
                        (hfb_reg == META_SMPTE && m_val[39])) begin
                        fail  = 1'b1;
                        f_err = ERR_KEY_SMPTE;
                    end else begin
                        fin    = 1'b1;
                        f_kind = KIND_META;
                        f_ch   = 4'hF;
                        f_fd   = hfb_reg;
                        f_val  = m_val;
                    end
                end

                if (fail) begin
                    err_next    = f_err;
                    mvalid_next = 1'b1;
                    mkind_next  = '0;
                    mlast_next  = 1'b0;
                    mdata_next  = {5'd0, f_err, total_next, track_reg, 28'd0, 40'd0,
                                   8'd0, 4'd0};
                end else if (fin) begin
                    done_flag = (bcnt_next >= clen_reg);
                    if (done_flag) begin
                        if (track_reg > total_next) total_next = track_reg;
                        phase_next = PH_TAG0;
                    end else begin
                        phase_next = PH_DELTA;
                    end
                    vlq_next    = '0;
                    mvalid_next = 1'b1;
                    mkind_next  = f_kind;
                    mlast_next  = done_flag;
                    mdata_next  = {5'd0, ERR_NONE, total_next, track_reg, hdelta_reg,
                                   f_val, f_fd, f_ch};
                end
            end
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mlast_reg;

endmodule

/* sv/mftp_time_unit.sv */
// Serial multiply of tempo by delta and divide by the time base times 1000 on one adder.
`timescale 1ns / 1ps
module mftp_time_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] tempo,
    input  logic [27:0] delta,
    input  logic [24:0] divisor,
    output logic        done,
    output logic [51:0] quotient
);
    import mftp_pkg::*;

    tu_state_t   state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [51:0] pd_reg, pd_next;
    logic [25:0] rem_reg, rem_next;
    logic [23:0] tempo_reg, tempo_next;
    logic [24:0] div_reg, div_next;
    logic        done_reg, done_next;
    logic [25:0] add_a, add_b;
    logic        add_sub;
    logic [26:0] sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg   <= cnt_next;
        pd_reg    <= pd_next;
        rem_reg   <= rem_next;
        tempo_reg <= tempo_next;
        div_reg   <= div_next;
    end

    assign sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + {26'd0, add_sub};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pd_next    = pd_reg;
        rem_next   = rem_reg;
        tempo_next = tempo_reg;
        div_next   = div_reg;
        done_next  = 1'b0;
        add_a      = {2'b0, pd_reg[51:28]};
        add_b      = {2'b0, tempo_reg};
        add_sub    = 1'b0;
        unique case (state_reg)
            TU_IDLE: begin
                if (start) begin
                    pd_next    = {24'd0, delta};
                    tempo_next = tempo;
                    div_next   = divisor;
                    cnt_next   = '0;
                    state_next = TU_MUL;
                end
            end
            TU_MUL: begin
                if (pd_reg[0]) begin
                    pd_next = {sum[24:0], pd_reg[27:1]};
                end else begin
                    pd_next = {1'b0, pd_reg[51:28], pd_reg[27:1]};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd27) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = TU_DIV;
                end
            end
            TU_DIV: begin
                add_a   = {rem_reg[24:0], pd_reg[51]};
                add_b   = {1'b0, div_reg};
                add_sub = 1'b1;
                rem_next = sum[26] ? sum[25:0] : add_a;
                pd_next  = {pd_reg[50:0], sum[26]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd51) begin
                    done_next  = 1'b1;
                    state_next = TU_IDLE;
                end
            end
            default: state_next = TU_IDLE;
        endcase
    end

    assign done     = done_reg;
    assign quotient = pd_reg;

endmodule
